>>> sv/bbc_pkg.sv
// Shared types, constants and character decode for the bracket balance checker.
package bbc_pkg;

  localparam int STACK_DEPTH_DEF = 64;

  localparam int KIND_W = 2;
  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_ROUND  = 2'd0;
  localparam kind_t KIND_SQUARE = 2'd1;
  localparam kind_t KIND_CURLY  = 2'd2;

  localparam logic [7:0] CHAR_OPEN_ROUND   = 8'h28;  // (
  localparam logic [7:0] CHAR_CLOSE_ROUND  = 8'h29;  // )
  localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;  // [
  localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;  // ]
  localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7B;  // {
  localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7D;  // }

  typedef struct packed {
    logic is_open;
    logic is_close;
    kind_t kind;
  } char_class_t;

  // one finished string verdict
  typedef struct packed {
    logic overflowed;
    logic balanced;
  } result_t;

  // result leaving the stack controller
  typedef struct packed {
    logic    valid;
    result_t data;
  } result_req_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    r = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
    case (c)
      CHAR_OPEN_ROUND:   r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ROUND};
      CHAR_OPEN_SQUARE:  r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_SQUARE};
      CHAR_OPEN_CURLY:   r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_CURLY};
      CHAR_CLOSE_ROUND:  r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ROUND};
      CHAR_CLOSE_SQUARE: r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_SQUARE};
      CHAR_CLOSE_CURLY:  r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_CURLY};
      default:           r = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
    endcase
    return r;
  endfunction

endpackage

>>> sv/bracket_balance_checker.sv
// Top level of the bracket balance checker: stack RAM, stack controller, result queue.
//
// Input stream (s_*): one text byte per transfer in s_tdata, s_tlast marks the
// last byte of a string. Round, square and curly brackets are checked for
// proper nesting; all other bytes pass without effect.
// Output stream (m_*): one transfer per string, after its last byte:
// m_tdata[0] balanced, m_tdata[1] overflowed (nesting beyond STACK_DEPTH).
// Throughput: one byte per cycle while the result queue keeps s_tready high; a
// push or pop per byte goes to the stack RAM, and a pop's kind compare happens
// the cycle after, off the RAM's registered read port.
// Output path: the last byte's verdict passes the compare stage, then the result
// queue register, before it is valid on m_*.
// Stall: the three-entry result queue absorbs verdicts while m_tready is low;
// s_tready drops only once the queue plus the compare stage fill it.
// Reset (rst, synchronous): clears stack level, error flags, pipeline and queue.
// The stack RAM itself is not cleared; only entries pushed in the current
// string are ever read.
module bracket_balance_checker #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_code
  input  logic       s_tlast,   // end_of_string
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] balanced, [1] overflowed, [7:2] zero
);

  localparam int AW = $clog2(STACK_DEPTH);

  logic                 accept;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  bbc_pkg::kind_t       mem_wdata, mem_rdata;
  bbc_pkg::result_req_t result;
  logic                 result_pending;
  bbc_pkg::result_t     out_data;

  assign accept = s_tvalid & s_tready;

  // open-bracket kinds, one per nesting level
  bbc_ram #(
    .WIDTH (bbc_pkg::KIND_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bbc_stack_ctrl #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .char_code      (s_tdata),
    .end_of_string  (s_tlast),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata),
    .result         (result),
    .result_pending (result_pending)
  );

  bbc_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .in_req     (result),
    .pending    (result_pending),
    .can_accept (s_tready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (out_data)
  );

  assign m_tdata = {6'b0, out_data.overflowed, out_data.balanced};

endmodule

>>> sv/bbc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module bbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/bbc_stack_ctrl.sv
// Stack controller: push/pop issue stage and kind-compare stage around the stack RAM.
module bbc_stack_ctrl #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [7:0]                     char_code,
  input  logic                           end_of_string,
  // stack RAM port
  output logic                           mem_we,
  output logic [$clog2(STACK_DEPTH)-1:0] mem_waddr,
  output bbc_pkg::kind_t                 mem_wdata,
  output logic                           mem_re,
  output logic [$clog2(STACK_DEPTH)-1:0] mem_raddr,
  input  bbc_pkg::kind_t                 mem_rdata,
  // verdict toward the result queue
  output bbc_pkg::result_req_t           result,
  output logic                           result_pending
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam logic [LW-1:0] LEVEL_FULL = LW'(STACK_DEPTH);

  // issue stage state
  logic [LW-1:0] level, level_next;
  logic          mismatch_seen, overflow_seen;

  // compare stage (byte accepted last cycle)
  logic           b_valid;
  logic           b_last;
  logic           b_pop;
  bbc_pkg::kind_t b_kind;
  logic           b_bal_pre;
  logic           b_ovf;

  bbc_pkg::char_class_t cls;
  logic b_kind_bad, mism_eff, ignore;
  logic push, pop, ovf_hit, underflow;
  logic mism_new, ovf_new;

  // pop of the previous byte resolves here; a verdict already taken by the
  // end of the old string must not leak into the new one
  assign b_kind_bad = b_valid & b_pop & (mem_rdata != b_kind);
  assign mism_eff   = mismatch_seen | (b_kind_bad & ~b_last);
  assign ignore     = mism_eff | overflow_seen;

  assign cls       = bbc_pkg::classify(char_code);
  assign push      = accept & ~ignore & cls.is_open & (level < LEVEL_FULL);
  assign ovf_hit   = accept & ~ignore & cls.is_open & (level >= LEVEL_FULL);
  assign pop       = accept & ~ignore & cls.is_close & (level != '0);
  assign underflow = accept & ~ignore & cls.is_close & (level == '0);

  assign mism_new = mism_eff | underflow;
  assign ovf_new  = overflow_seen | ovf_hit;

  always_comb begin
    level_next = level;
    if (push) begin
      level_next = level + LW'(1);
    end else if (pop) begin
      level_next = level - LW'(1);
    end
  end

  // write of a push lands before any later pop can read it, so no bypass
  assign mem_we    = push;
  assign mem_waddr = level[AW-1:0];
  assign mem_wdata = cls.kind;
  assign mem_re    = pop;
  assign mem_raddr = level_next[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      level         <= '0;
      mismatch_seen <= 1'b0;
      overflow_seen <= 1'b0;
      b_valid       <= 1'b0;
    end else begin
      b_valid <= accept;
      if (accept && end_of_string) begin
        level         <= '0;
        mismatch_seen <= 1'b0;
        overflow_seen <= 1'b0;
      end else if (accept) begin
        level         <= level_next;
        mismatch_seen <= mism_new;
        overflow_seen <= ovf_new;
      end else begin
        mismatch_seen <= mism_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_last    <= end_of_string;
      b_pop     <= pop;
      b_kind    <= cls.kind;
      b_bal_pre <= ~mism_new & ~ovf_new & (level_next == '0);
      b_ovf     <= ovf_new;
    end
  end

  assign result.valid           = b_valid & b_last;
  assign result.data.balanced   = b_bal_pre & ~b_kind_bad;
  assign result.data.overflowed = b_ovf;
  assign result_pending         = b_valid & b_last;

endmodule

>>> sv/bbc_result_queue.sv
// Three-entry result queue that decouples the output channel from the stack pipeline.
module bbc_result_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  bbc_pkg::result_req_t in_req,
  input  logic                 pending,
  output logic                 can_accept,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bbc_pkg::result_t     out_data
);

  localparam int QD = 3;
  localparam int PW = $clog2(QD);
  localparam int CW = $clog2(QD + 1);

  bbc_pkg::result_t entries [QD];
  logic [PW-1:0] head, tail;
  logic [CW-1:0] count;
  logic          wr, rd;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QD - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wr = in_req.valid;
  assign rd = out_valid & out_ready;

  assign out_valid  = (count != '0);
  assign out_data   = entries[head];
  // a verdict still in the compare stage holds a slot
  assign can_accept = ((count + CW'(pending)) < CW'(QD));

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        tail <= ptr_inc(tail);
      end
      if (rd) begin
        head <= ptr_inc(head);
      end
      case ({wr, rd})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[tail] <= in_req.data;
    end
  end

endmodule
